[rtl/ppl_pkg.sv]
// ----------------------------------------------------------------------------
// ppl_pkg
// Shared constants, types and helpers of the point projection luminance plotter.
// ----------------------------------------------------------------------------
package ppl_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 256;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int ROW_W      = 8;
    localparam int COL_W      = 9;
    localparam int BRT_W      = 15;
    localparam int NUM_W      = 28;
    localparam int DEN_W      = 17;
    localparam int ONE_Q14    = 16384;
    localparam int GLYPH_STEPS = 11;

    localparam logic [3:0] GLYPH_BLANK = 4'd12;

    localparam logic [1:0] REQ_PLOT  = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [2:0] CFG_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_DIST    = 3'd2;
    localparam logic [2:0] CFG_LIGHT_X = 3'd3;
    localparam logic [2:0] CFG_LIGHT_Y = 3'd4;
    localparam logic [2:0] CFG_LIGHT_Z = 3'd5;

    typedef struct packed {
        logic              re;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [BRT_W-1:0]  wdata;
    } ppl_mem_req_t;

    function automatic logic [3:0] glyph_of(input logic [BRT_W-1:0] b);
        logic [BRT_W+3:0] prod;
        prod = {4'd0, b} * (BRT_W+4)'(GLYPH_STEPS);
        if (b == '0) begin
            return GLYPH_BLANK;
        end
        return prod[17:14];
    endfunction

endpackage

[rtl/project_point_luminance_plot_core.sv]
// ----------------------------------------------------------------------------
// project_point_luminance_plot_core
// Flow: plot beats pass multiply, prep, the 28-step projection divider, read
// and merge; zero-depth plots skip the divider; clear and read start at read.
// Throughput: one beat at a time, next beat accepted once the previous one
// has written its result register.
// Reset: after aresetn a clearing sweep zeroes all 131072 cells, one per
// cycle; no beat is accepted during it, configuration writes still are.
// ----------------------------------------------------------------------------
module project_point_luminance_plot_core
    import ppl_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [2:0]              cfg_index,
    input  logic [15:0]             cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_req_type,
    input  logic signed [15:0]      s_point_x,
    input  logic signed [15:0]      s_point_y,
    input  logic signed [15:0]      s_point_z,
    input  logic signed [15:0]      s_normal_x,
    input  logic signed [15:0]      s_normal_y,
    input  logic signed [15:0]      s_normal_z,
    input  logic [ROW_W-1:0]        s_cell_row,
    input  logic [COL_W-1:0]        s_cell_col,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [ROW_W-1:0]        m_out_row,
    output logic [COL_W-1:0]        m_out_col,
    output logic                    m_updated,
    output logic [3:0]              m_glyph,
    output logic signed [15:0]      m_brightness
);

    typedef enum logic [6:0] {
        ST_INIT  = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_PREP  = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_READ  = 7'b0100000,
        ST_MERGE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [9:0]         width_reg;
    logic [8:0]         height_reg;
    logic [9:0]         dist_reg;
    logic signed [15:0] light_x_reg, light_y_reg, light_z_reg;

    logic [1:0]         req_reg;
    logic signed [15:0] px_reg, py_reg, pz_reg, nx_reg, ny_reg, nz_reg;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;

    logic signed [31:0] dot_x_reg, dot_y_reg, dot_z_reg;
    logic signed [24:0] hz_reg;
    logic signed [26:0] dy_reg;
    logic signed [25:0] wz_reg;
    logic signed [26:0] dx_reg;
    logic signed [15:0] bright_reg;
    logic               neg_row_reg, neg_col_reg;

    logic               m_valid_reg;
    logic [ROW_W-1:0]   m_row_reg;
    logic [COL_W-1:0]   m_col_reg;
    logic               m_upd_reg;
    logic [3:0]         m_glyph_reg;
    logic signed [15:0] m_bright_reg;

    logic [9:0]         w_eff;
    logic [8:0]         h_eff;
    logic [8:0]         half_w;
    logic [7:0]         half_h;

    logic signed [33:0] dot_sum;
    logic [33:0]        dot_mag;
    logic [33:0]        dot_rnd;
    logic [15:0]        dot_sat;
    logic signed [27:0] num_row, num_col;
    logic [27:0]        mag_row, mag_col;
    logic [15:0]        mag_z;
    logic [NUM_W-1:0]   dvd_row, dvd_col;
    logic [DEN_W-1:0]   dvs;
    logic               div_start;
    logic               div_done_row, div_done_col;
    logic [NUM_W-1:0]   quo_row, quo_col;
    logic               row_ok, col_ok;

    ppl_mem_req_t       mem_req;
    logic [BRT_W-1:0]   rd_data;
    logic               init_done;
    logic               out_free;
    logic               in_range;
    logic               plot_upd;
    logic               merge_fire;

    assign w_eff  = (width_reg == '0) ? 10'd1 :
                    (width_reg > 10'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : width_reg;
    assign h_eff  = (height_reg == '0) ? 9'd1 :
                    (height_reg > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_reg;
    assign half_w = w_eff[9:1];
    assign half_h = h_eff[8:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= 10'd400;
            height_reg  <= 9'd160;
            dist_reg    <= 10'd80;
            light_x_reg <= 16'sd0;
            light_y_reg <= 16'sd7327;
            light_z_reg <= -16'sd14654;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_WIDTH:   width_reg   <= cfg_wdata[9:0];
                CFG_HEIGHT:  height_reg  <= cfg_wdata[8:0];
                CFG_DIST:    dist_reg    <= cfg_wdata[9:0];
                CFG_LIGHT_X: light_x_reg <= cfg_wdata;
                CFG_LIGHT_Y: light_y_reg <= cfg_wdata;
                CFG_LIGHT_Z: light_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign dot_sum = 34'(dot_x_reg) + 34'(dot_y_reg) + 34'(dot_z_reg);
    assign dot_mag = dot_sum[33] ? 34'(-dot_sum) : 34'(dot_sum);
    assign dot_rnd = (dot_mag + 34'd8192) >> 14;
    assign dot_sat = (dot_rnd > 34'(ONE_Q14)) ? 16'(ONE_Q14) : dot_rnd[15:0];

    assign num_row = 28'(hz_reg) - 28'(dy_reg);
    assign num_col = 28'(wz_reg) + 28'(dx_reg);
    assign mag_row = num_row[27] ? 28'(-num_row) : 28'(num_row);
    assign mag_col = num_col[27] ? 28'(-num_col) : 28'(num_col);
    assign mag_z   = pz_reg[15] ? 16'(-pz_reg) : 16'(pz_reg);
    assign dvd_row = {mag_row[26:0], 1'b0} + NUM_W'(mag_z);
    assign dvd_col = {mag_col[26:0], 1'b0} + NUM_W'(mag_z);
    assign dvs     = {mag_z, 1'b0};

    assign div_start = (state_reg == ST_PREP) && (pz_reg != '0);

    ppl_div u_div_row (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dvd_row),
        .divisor  (dvs),
        .done     (div_done_row),
        .quotient (quo_row)
    );

    ppl_div u_div_col (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dvd_col),
        .divisor  (dvs),
        .done     (div_done_col),
        .quotient (quo_col)
    );

    assign row_ok = (!neg_row_reg || quo_row == '0) && (quo_row < NUM_W'(h_eff));
    assign col_ok = (!neg_col_reg || quo_col == '0) && (quo_col < NUM_W'(w_eff));

    assign out_free   = !m_valid_reg || m_ready;
    assign in_range   = (9'(row_reg) < h_eff) && (10'(col_reg) < w_eff);
    assign plot_upd   = bright_reg > $signed({1'b0, rd_data});
    assign merge_fire = (state_reg == ST_MERGE) && out_free;

    always_comb begin
        mem_req.re    = (state_reg == ST_READ);
        mem_req.addr  = ADDR_W'(row_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_reg);
        mem_req.we    = 1'b0;
        mem_req.wdata = '0;
        if (merge_fire) begin
            if (req_reg == REQ_PLOT) begin
                mem_req.we    = plot_upd;
                mem_req.wdata = bright_reg[BRT_W-1:0];
            end else if (req_reg == REQ_CLEAR) begin
                mem_req.we = in_range;
            end
        end
    end

    ppl_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mem_req   (mem_req),
        .rd_data   (rd_data),
        .init_done (init_done)
    );

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        case (state_reg)
            ST_INIT: begin
                if (init_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    row_next   = s_cell_row;
                    col_next   = s_cell_col;
                    state_next = (s_req_type == REQ_PLOT) ? ST_MUL : ST_READ;
                end
            end
            ST_MUL: state_next = ST_PREP;
            ST_PREP: begin
                if (pz_reg == '0) begin
                    row_next   = '0;
                    col_next   = '0;
                    state_next = ST_READ;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done_row && div_done_col) begin
                    if (row_ok && col_ok) begin
                        row_next = quo_row[ROW_W-1:0];
                        col_next = quo_col[COL_W-1:0];
                    end else begin
                        row_next = '0;
                        col_next = '0;
                    end
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_MERGE;
            ST_MERGE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg <= row_next;
        col_reg <= col_next;
        if (s_valid && s_ready) begin
            req_reg <= s_req_type;
            px_reg  <= s_point_x;
            py_reg  <= s_point_y;
            pz_reg  <= s_point_z;
            nx_reg  <= s_normal_x;
            ny_reg  <= s_normal_y;
            nz_reg  <= s_normal_z;
        end
        if (state_reg == ST_MUL) begin
            dot_x_reg <= light_x_reg * nx_reg;
            dot_y_reg <= light_y_reg * ny_reg;
            dot_z_reg <= light_z_reg * nz_reg;
            hz_reg    <= $signed({1'b0, half_h}) * pz_reg;
            dy_reg    <= $signed({1'b0, dist_reg}) * py_reg;
            wz_reg    <= $signed({1'b0, half_w}) * pz_reg;
            dx_reg    <= $signed({1'b0, dist_reg}) * px_reg;
        end
        if (state_reg == ST_PREP) begin
            bright_reg  <= dot_sum[33] ? 16'(-dot_sat) : dot_sat;
            neg_row_reg <= num_row[27] ^ pz_reg[15];
            neg_col_reg <= num_col[27] ^ pz_reg[15];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (merge_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (merge_fire) begin
            m_row_reg    <= row_reg;
            m_col_reg    <= col_reg;
            m_upd_reg    <= 1'b0;
            m_glyph_reg  <= GLYPH_BLANK;
            m_bright_reg <= '0;
            if (req_reg == REQ_PLOT) begin
                m_upd_reg    <= plot_upd;
                m_glyph_reg  <= glyph_of(plot_upd ? bright_reg[BRT_W-1:0] : rd_data);
                m_bright_reg <= bright_reg;
            end else if (req_reg == REQ_READ && in_range) begin
                m_glyph_reg  <= glyph_of(rd_data);
                m_bright_reg <= $signed({1'b0, rd_data});
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_row    = m_row_reg;
    assign m_out_col    = m_col_reg;
    assign m_updated    = m_upd_reg;
    assign m_glyph      = m_glyph_reg;
    assign m_brightness = m_bright_reg;

endmodule

[rtl/ppl_div.sv]
// ----------------------------------------------------------------------------
// ppl_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppl_div
    import ppl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(NUM_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            den_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/ppl_store.sv]
// ----------------------------------------------------------------------------
// ppl_store
// Brightness memory with registered read and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module ppl_store
    import ppl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  ppl_mem_req_t     mem_req,
    output logic [BRT_W-1:0] rd_data,
    output logic             init_done
);

    logic [BRT_W-1:0]  mem [DEPTH];
    logic [BRT_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_cnt_reg] <= '0;
        end else if (mem_req.we) begin
            mem[mem_req.addr] <= mem_req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_req.re) begin
            rd_data_reg <= mem[mem_req.addr];
        end
    end

    assign rd_data   = rd_data_reg;
    assign init_done = !clr_busy_reg;

endmodule

[verif/tb_project_point_luminance_plot_core.sv]
// ----------------------------------------------------------------------------
// tb_project_point_luminance_plot_core
// Self-checking bench for the point projection luminance plotter. A local
// brightness buffer and projector predict every result beat; directed beats
// cover rounding ties, saturation, off-screen and zero-depth plots, blank and
// out-of-range cells, then random plot, read and clear traffic runs under
// several screen and light settings with random idling and back pressure.
// ----------------------------------------------------------------------------
module tb_project_point_luminance_plot_core;
    import ppl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]         req;
        logic signed [15:0] px, py, pz, nx, ny, nz;
        logic [7:0]         row;
        logic [8:0]         col;
    } plot_req_t;

    typedef struct {
        logic [7:0]         row;
        logic [8:0]         col;
        logic               upd;
        logic [3:0]         glyph;
        logic signed [15:0] brt;
    } plot_res_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_req_type = '0;
    logic signed [15:0] s_point_x = '0, s_point_y = '0, s_point_z = '0;
    logic signed [15:0] s_normal_x = '0, s_normal_y = '0, s_normal_z = '0;
    logic [7:0]         s_cell_row = '0;
    logic [8:0]         s_cell_col = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [7:0]         m_out_row;
    logic [8:0]         m_out_col;
    logic               m_updated;
    logic [3:0]         m_glyph;
    logic signed [15:0] m_brightness;

    logic [14:0]        brt_store [0:DEPTH-1];
    logic [9:0]         scr_w = 10'd400;
    logic [8:0]         scr_h = 9'd160;
    logic [9:0]         focal = 10'd80;
    logic signed [15:0] lgt_x = 16'sd0, lgt_y = 16'sd7327, lgt_z = -16'sd14654;

    plot_res_t          expected_q[$];
    int                 errors = 0;
    bit                 calm = 1'b0;
    int                 hold_cycles = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    project_point_luminance_plot_core dut (.*);

    initial begin
        #25ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic longint div_round(longint n, longint d);
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        if (n >= 0) return (2 * n + d) / (2 * d);
        return -((2 * (-n) + d) / (2 * d));
    endfunction

    function automatic logic [3:0] glyph_calc(longint b);
        if (b <= 0) return GLYPH_BLANK;
        return 4'((b * GLYPH_STEPS) >>> 14);
    endfunction

    function automatic longint eff_w();
        if (scr_w == 0) return 1;
        return (scr_w > MAX_WIDTH) ? MAX_WIDTH : scr_w;
    endfunction

    function automatic longint eff_h();
        if (scr_h == 0) return 1;
        return (scr_h > MAX_HEIGHT) ? MAX_HEIGHT : scr_h;
    endfunction

    function automatic plot_res_t predict_cell(plot_req_t it);
        plot_res_t r;
        longint w, h, row, col, s, br, idx;
        w = eff_w();
        h = eff_h();
        row = it.row;
        col = it.col;
        br = 0;
        r.upd = 1'b0;
        r.glyph = GLYPH_BLANK;
        if (it.req == REQ_PLOT) begin
            s = longint'(lgt_x) * longint'(it.nx) + longint'(lgt_y) * longint'(it.ny)
                + longint'(lgt_z) * longint'(it.nz);
            br = (s >= 0) ? ((s + 8192) >>> 14) : -(((-s) + 8192) >>> 14);
            if (br > ONE_Q14) br = ONE_Q14;
            if (br < -ONE_Q14) br = -ONE_Q14;
            if (it.pz == 0) begin
                row = 0;
                col = 0;
            end else begin
                row = div_round((h / 2) * it.pz - longint'(focal) * it.py, it.pz);
                col = div_round((w / 2) * it.pz + longint'(focal) * it.px, it.pz);
                if (row < 0 || row >= h || col < 0 || col >= w) begin
                    row = 0;
                    col = 0;
                end
            end
            idx = row * MAX_WIDTH + col;
            if (br > longint'(brt_store[idx])) begin
                brt_store[idx] = 15'(br);
                r.upd = 1'b1;
            end
            r.glyph = glyph_calc(brt_store[idx]);
        end else if ((it.req == REQ_CLEAR || it.req == REQ_READ) && row < h && col < w) begin
            idx = row * MAX_WIDTH + col;
            if (it.req == REQ_CLEAR) begin
                brt_store[idx] = '0;
            end else begin
                br = brt_store[idx];
                r.glyph = glyph_calc(br);
            end
        end
        r.row = 8'(row);
        r.col = 9'(col);
        r.brt = 16'(br);
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        plot_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report("unexpected beat row", m_out_row, 0);
            end else begin
                e = expected_q.pop_front();
                if (m_out_row !== e.row) report("out_row", m_out_row, e.row);
                if (m_out_col !== e.col) report("out_col", m_out_col, e.col);
                if (m_updated !== e.upd) report("updated", m_updated, e.upd);
                if (m_glyph !== e.glyph) report("glyph", m_glyph, e.glyph);
                if (m_brightness !== e.brt) report("brightness", m_brightness, e.brt);
            end
        end
    end

    // receiver: random stalls, or a counted hold-off
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready = 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            m_ready = calm ? 1'b1 : ($urandom_range(99) >= 6);
        end
    end

    task automatic send_req(plot_req_t it);
        if (!calm) begin
            while ($urandom_range(99) < 6) begin
                s_valid = 1'b0;
                @(negedge aclk);
            end
        end
        s_req_type = it.req;
        s_point_x = it.px;
        s_point_y = it.py;
        s_point_z = it.pz;
        s_normal_x = it.nx;
        s_normal_y = it.ny;
        s_normal_z = it.nz;
        s_cell_row = it.row;
        s_cell_col = it.col;
        s_valid = 1'b1;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        expected_q.push_back(predict_cell(it));
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_WIDTH:   scr_w = val[9:0];
            CFG_HEIGHT:  scr_h = val[8:0];
            CFG_DIST:    focal = val[9:0];
            CFG_LIGHT_X: lgt_x = val;
            CFG_LIGHT_Y: lgt_y = val;
            CFG_LIGHT_Z: lgt_z = val;
            default: ;
        endcase
    endtask

    task automatic set_screen(int w, int h, int d, int lx, int ly, int lz);
        write_reg(CFG_WIDTH, 16'(w));
        write_reg(CFG_HEIGHT, 16'(h));
        write_reg(CFG_DIST, 16'(d));
        write_reg(CFG_LIGHT_X, 16'(lx));
        write_reg(CFG_LIGHT_Y, 16'(ly));
        write_reg(CFG_LIGHT_Z, 16'(lz));
    endtask

    function automatic plot_req_t mk(logic [1:0] req, int px, int py, int pz,
                                     int nx, int ny, int nz, int row = 0, int col = 0);
        plot_req_t it;
        it.req = req;
        it.px = 16'(px);
        it.py = 16'(py);
        it.pz = 16'(pz);
        it.nx = 16'(nx);
        it.ny = 16'(ny);
        it.nz = 16'(nz);
        it.row = 8'(row);
        it.col = 9'(col);
        return it;
    endfunction

    function automatic int rnd_q14();
        return int'($urandom_range(32768)) - 16384;
    endfunction

    function automatic int clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    // well-formed plot aimed at one of a small grid of cells, read or clear traffic on it, or a random beat
    function automatic plot_req_t rnd_req();
        plot_req_t it;
        longint w, h, tr, tc, z;
        int pick;
        w = eff_w();
        h = eff_h();
        tr = $urandom_range(7) * (h - 1) / 7;
        tc = $urandom_range(7) * (w - 1) / 7;
        pick = $urandom_range(99);
        z = $urandom_range(4000, 16);
        if ($urandom_range(3) == 0) z = -z;
        it = mk(REQ_PLOT, 0, 0, int'(z), rnd_q14(), rnd_q14(), rnd_q14(),
                int'(tr), int'(tc));
        if (pick < 70) begin
            if (focal != 0) begin
                it.px = 16'(clip16((tc - w / 2) * z / longint'(focal)
                                   + longint'($urandom_range(2)) - 1));
                it.py = 16'(clip16((h / 2 - tr) * z / longint'(focal)
                                   + longint'($urandom_range(2)) - 1));
            end else begin
                it.px = 16'($urandom);
                it.py = 16'($urandom);
            end
        end else if (pick < 80) begin
            it.req = REQ_READ;
        end else if (pick < 85) begin
            it.req = REQ_CLEAR;
        end else begin
            it.req = 2'($urandom_range(3));
            it.px = 16'($urandom);
            it.py = 16'($urandom);
            it.pz = 16'($urandom);
            it.row = 8'($urandom);
            it.col = 9'($urandom);
        end
        return it;
    endfunction

    task automatic test_directed_defaults();
        send_req(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        send_req(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 255, 511));
        send_req(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 255, 511));
        send_req(mk(2'd3, 0, 0, 0, 0, 0, 0, 255, 511));
        send_req(mk(REQ_PLOT, 100, 100, 0, 0, 16384, 0));
        send_req(mk(REQ_PLOT, 0, 0, 256, 0, 16384, 0));
        send_req(mk(REQ_PLOT, 0, 0, 256, 0, 8000, 0));
        send_req(mk(REQ_PLOT, 0, 0, 256, 0, 0, -16384));
        send_req(mk(REQ_PLOT, 1, 1, 160, 0, 16384, 0));
        send_req(mk(REQ_PLOT, -1, -1, 160, 0, 16384, 0));
        send_req(mk(REQ_PLOT, 32767, 0, 1, 0, 16384, 0));
        send_req(mk(REQ_PLOT, -32768, -32768, -32768, -16384, -16384, 16384));
        send_req(mk(REQ_PLOT, 32767, 32767, 32767, 16384, 16384, 16384));
        send_req(mk(REQ_PLOT, 256, 0, -256, 0, -16384, 0));
        send_req(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 80, 200));
        send_req(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 80, 200));
        send_req(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 80, 200));
        drain();
    endtask

    task automatic test_config_extremes();
        set_screen(0, 0, 0, 16384, 16384, 16384);
        send_req(mk(REQ_PLOT, 500, -500, 300, 16384, 16384, 16384));
        send_req(mk(REQ_PLOT, 5, 5, 3, -16384, -16384, -16384));
        send_req(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        send_req(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 1));
        drain();
        set_screen(1023, 511, 1023, 1, -16384, -16384);
        send_req(mk(REQ_PLOT, 0, 0, 100, 8192, 0, 0));
        send_req(mk(REQ_PLOT, 0, 0, 100, -8192, 0, 0));
        send_req(mk(REQ_PLOT, 31, -31, 32767, 1, 0, -16384));
        send_req(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 255, 511));
        send_req(mk(REQ_PLOT, 1, 1, 2046, 0, -16384, 0));
        drain();
        set_screen(1, 1, 1, -16384, 0, 0);
        send_req(mk(REQ_PLOT, 1, 1, 2, -16384, 0, 0));
        send_req(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        drain();
    endtask

    task automatic test_random_traffic(int count);
        plot_req_t it;
        for (int i = 0; i < count; i++) begin
            calm = (i >= count / 2 && i < count / 2 + 60);
            it = rnd_req();
            send_req(it);
        end
        calm = 1'b0;
        drain();
    endtask

    task automatic test_backpressure();
        plot_req_t it;
        calm = 1'b1;
        hold_cycles = 300;
        for (int i = 0; i < 20; i++) begin
            it = rnd_req();
            send_req(it);
        end
        calm = 1'b0;
        drain();
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) brt_store[i] = '0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        test_directed_defaults();
        test_config_extremes();
        set_screen(400, 160, 80, 0, 7327, -14654);
        test_random_traffic(300);
        set_screen(512, 256, 1023, rnd_q14(), rnd_q14(), rnd_q14());
        test_random_traffic(300);
        set_screen(37, 19, 5, rnd_q14(), rnd_q14(), rnd_q14());
        test_random_traffic(300);
        set_screen(100, 60, 200, 9000, -9000, 9000);
        test_backpressure();
        test_random_traffic(380);
        drain();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/ppl_pkg.sv
rtl/ppl_div.sv
rtl/ppl_store.sv
rtl/project_point_luminance_plot_core.sv
verif/tb_project_point_luminance_plot_core.sv
